@@ rtl/pcht_pkg.sv @@
// shared opcodes, status codes and handshake type for the position count table
`timescale 1ns / 1ps
`default_nettype none
package pcht_pkg;
    localparam int WORD_W  = 64;
    localparam int COUNT_W = 32;
    localparam int FOLD_W  = 31;
    localparam int HALF_W  = 32;
    // bucket remainder unit: steps per key
    localparam int DIV_STEPS = 2;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_GET    = 2'd2,
        OP_CLEAR  = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } t_status;

    typedef struct packed {
        logic valid;
        logic stall;
    } t_hs;
endpackage
`default_nettype wire

@@ rtl/pcht_fifo.sv @@
// two-entry request queue between front and back
`timescale 1ns / 1ps
`default_nettype none
module pcht_fifo import pcht_pkg::*; #(
    parameter int WIDTH = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output t_hs                   o_hs,
    output logic [WIDTH-1:0]      o_data
);
    logic [WIDTH-1:0] r_mem [2];
    logic             r_wp, r_rp;
    logic [1:0]       r_cnt;

    assign o_full     = (r_cnt == 2'd2);
    assign o_hs.valid = (r_cnt != 2'd0);
    assign o_hs.stall = o_full;
    assign o_data     = r_mem[r_rp];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end
endmodule
`default_nettype wire

@@ rtl/pcht_front.sv @@
// word collection, hash fold and bucket remainder
`timescale 1ns / 1ps
`default_nettype none
module pcht_front import pcht_pkg::*; #(
    parameter int BUCKETS   = 256,
    parameter int KEY_WORDS = 12,
    parameter int BW        = 8,
    parameter int QW        = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire logic [1:0]        i_opcode,
    input  wire logic [WORD_W-1:0] i_key_word,
    output logic                   o_push,
    output logic [QW-1:0]          o_push_data,
    input  wire logic              i_q_full
);
    localparam int CW = (KEY_WORDS > 1) ? $clog2(KEY_WORDS) : 1;
    localparam int KW = KEY_WORDS * WORD_W;
    localparam int SH = FOLD_W + BW;
    localparam int PW = FOLD_W + HALF_W;
    // rounded-up reciprocal, exact quotient for every fold value
    localparam logic [HALF_W-1:0] RECIP =
        HALF_W'(((64'd1 << SH) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS));

    logic [KEY_WORDS-1:0][WORD_W-1:0] r_key, n_full_key;
    logic [CW-1:0]                    r_cnt;
    logic [WORD_W-1:0]                r_acc, n_acc;
    logic                             r_busy;
    logic [3:0]                       r_step;
    logic [FOLD_W-1:0]                r_x, w_quo;
    logic [PW-1:0]                    r_prod;
    logic [BW-1:0]                    r_rem;
    logic [1:0]                       r_pop;
    logic [KW-1:0]                    r_pkey;
    logic                             w_accept, w_last, w_clear, w_done;
    logic [FOLD_W-1:0]                w_fold;

    assign o_in_stall = r_busy || i_q_full;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_clear    = (i_opcode == OP_CLEAR);
    assign w_last     = (r_cnt == CW'(KEY_WORDS - 1));
    assign w_done     = r_busy && (r_step == 4'(DIV_STEPS));
    assign n_acc      = r_acc ^ ~i_key_word;
    assign w_fold     = FOLD_W'((n_acc >> HALF_W) ^ n_acc);
    assign w_quo      = FOLD_W'(r_prod >> SH);

    // key with the current word in place
    always_comb begin
        n_full_key        = r_key;
        n_full_key[r_cnt] = i_key_word;
    end

    // queue push: finished lookup request or a clear
    always_comb begin
        o_push      = 1'b0;
        o_push_data = {OP_CLEAR, {BW{1'b0}}, {KW{1'b0}}};
        if (w_done && !i_q_full) begin
            o_push      = 1'b1;
            o_push_data = {r_pop, r_rem, r_pkey};
        end else if (w_accept && w_clear) begin
            o_push = 1'b1;
        end
    end

    // key buffer
    always_ff @(posedge i_clk) begin
        if (w_accept && !w_clear) begin
            r_key[r_cnt] <= i_key_word;
        end
    end

    // word counter, hash and remainder unit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_acc  <= '0;
            r_busy <= 1'b0;
            r_step <= '0;
        end else begin
            if (w_accept) begin
                if (w_clear || w_last) begin
                    r_cnt <= '0;
                    r_acc <= '0;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                    r_acc <= n_acc;
                end
                if (!w_clear && w_last) begin
                    r_busy <= 1'b1;
                    r_step <= '0;
                    r_x    <= w_fold;
                    r_pop  <= i_opcode;
                    r_pkey <= n_full_key;
                end
            end else if (r_busy && !w_done) begin
                // reciprocal product, then fold minus quotient times buckets
                r_step <= r_step + 4'd1;
                r_prod <= PW'(r_x) * PW'(RECIP);
                r_rem  <= BW'(r_x - FOLD_W'(w_quo * FOLD_W'(BUCKETS)));
            end else if (w_done && !i_q_full) begin
                r_busy <= 1'b0;
            end
        end
    end
endmodule
`default_nettype wire

@@ rtl/pcht_back.sv @@
// bucket lookup, count update and result register
`timescale 1ns / 1ps
`default_nettype none
module pcht_back import pcht_pkg::*; #(
    parameter int BUCKETS   = 256,
    parameter int WAYS      = 4,
    parameter int KEY_WORDS = 12,
    parameter int BW        = 8,
    parameter int QW        = 8
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  t_hs                     i_q_hs,
    input  wire logic [QW-1:0]      i_q_data,
    output logic                    o_pop,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic [1:0]              o_status,
    output logic [COUNT_W-1:0]      o_occurrences
);
    localparam int ENTRIES = BUCKETS * WAYS;
    localparam int EW = $clog2(ENTRIES);
    localparam int WW = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int RC = $clog2(WAYS + 1);
    localparam int KW = KEY_WORDS * WORD_W;

    typedef enum logic [1:0] {S_IDLE, S_LOOK, S_DO} t_state;

    logic [KW-1:0]      key_mem [ENTRIES];
    logic [COUNT_W-1:0] cnt_mem [ENTRIES];
    logic [ENTRIES-1:0] r_valid;

    t_state             r_state;
    logic [1:0]         r_op;
    logic [EW-1:0]      r_base;
    logic [KW-1:0]      r_key;
    logic [RC-1:0]      r_rd_w;
    logic               r_cmp_vld;
    logic [WW-1:0]      r_cmp_w;
    logic               r_found, r_free;
    logic [EW-1:0]      r_hit, r_fidx;
    logic [COUNT_W-1:0] r_hitc;
    logic [KW-1:0]      r_rd_key;
    logic [COUNT_W-1:0] r_rd_cnt;
    logic [EW-1:0]      w_rd_addr, w_cmp_idx;
    logic               w_rd_en, w_out_free;
    logic               w_kwe, w_cwe;
    logic [EW-1:0]      w_waddr;
    logic [COUNT_W-1:0] w_wcnt;
    logic [BW-1:0]      w_q_bucket;

    assign w_q_bucket = i_q_data[KW +: BW];
    assign w_out_free = !o_out_valid || !i_out_stall;
    assign o_pop      = (r_state == S_IDLE) && i_q_hs.valid;
    assign w_rd_en    = (r_state == S_LOOK) && (r_rd_w < RC'(WAYS));
    assign w_rd_addr  = r_base + EW'(r_rd_w);
    assign w_cmp_idx  = r_base + EW'(r_cmp_w);

    // memory write selection for the update step
    always_comb begin
        w_kwe   = 1'b0;
        w_cwe   = 1'b0;
        w_waddr = r_hit;
        w_wcnt  = r_hitc;
        if (r_state == S_DO && w_out_free) begin
            case (r_op)
                OP_ADD: begin
                    if (r_found) begin
                        w_cwe  = 1'b1;
                        w_wcnt = (r_hitc == COUNT_MAX) ? r_hitc : r_hitc + 1'b1;
                    end else if (r_free) begin
                        w_kwe   = 1'b1;
                        w_cwe   = 1'b1;
                        w_waddr = r_fidx;
                        w_wcnt  = COUNT_W'(1);
                    end
                end
                OP_REMOVE: begin
                    if (r_found && r_hitc > COUNT_W'(1)) begin
                        w_cwe  = 1'b1;
                        w_wcnt = r_hitc - 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // key and count memories
    always_ff @(posedge i_clk) begin
        if (w_kwe) key_mem[w_waddr] <= r_key;
        if (w_cwe) cnt_mem[w_waddr] <= w_wcnt;
        if (w_rd_en) begin
            r_rd_key <= key_mem[w_rd_addr];
            r_rd_cnt <= cnt_mem[w_rd_addr];
        end
    end

    // sequencer, valid bits and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_cmp_vld   <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) o_out_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_q_hs.valid) begin
                        r_op      <= i_q_data[KW+BW +: 2];
                        r_key     <= i_q_data[KW-1:0];
                        r_base    <= EW'(w_q_bucket) * EW'(WAYS);
                        r_rd_w    <= '0;
                        r_cmp_vld <= 1'b0;
                        r_found   <= 1'b0;
                        r_free    <= 1'b0;
                        r_state   <= (i_q_data[KW+BW +: 2] == OP_CLEAR) ? S_DO : S_LOOK;
                    end
                end
                S_LOOK: begin
                    r_cmp_vld <= w_rd_en;
                    r_cmp_w   <= WW'(r_rd_w);
                    if (w_rd_en) r_rd_w <= r_rd_w + 1'b1;
                    // check the way read last cycle
                    if (r_cmp_vld) begin
                        if (r_valid[w_cmp_idx]) begin
                            if (!r_found && r_rd_key == r_key) begin
                                r_found <= 1'b1;
                                r_hit   <= w_cmp_idx;
                                r_hitc  <= r_rd_cnt;
                            end
                        end else if (!r_free) begin
                            r_free <= 1'b1;
                            r_fidx <= w_cmp_idx;
                        end
                        if (r_cmp_w == WW'(WAYS - 1)) r_state <= S_DO;
                    end
                end
                S_DO: begin
                    if (w_out_free) begin
                        o_out_valid   <= 1'b1;
                        o_status      <= ST_OK;
                        o_occurrences <= '0;
                        r_state       <= S_IDLE;
                        case (r_op)
                            OP_CLEAR: begin
                                r_valid <= '0;
                            end
                            OP_ADD: begin
                                if (r_found) begin
                                    o_occurrences <= w_wcnt;
                                end else if (r_free) begin
                                    r_valid[r_fidx] <= 1'b1;
                                    o_occurrences   <= COUNT_W'(1);
                                end else begin
                                    o_status <= ST_FULL;
                                end
                            end
                            OP_REMOVE: begin
                                if (!r_found) begin
                                    o_status <= ST_NOT_FOUND;
                                end else if (r_hitc > COUNT_W'(1)) begin
                                    o_occurrences <= w_wcnt;
                                end else begin
                                    r_valid[r_hit] <= 1'b0;
                                end
                            end
                            default: begin
                                if (!r_found) o_status <= ST_NOT_FOUND;
                                else          o_occurrences <= r_hitc;
                            end
                        endcase
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

@@ rtl/position_count_hash_table.sv @@
// top level of the counting hash table keyed by multi-word positions
`timescale 1ns / 1ps
`default_nettype none
// Counting multiset keyed by KEY_WORDS 64-bit words, one word per request,
// the opcode read on the last word (clear acts on any word). After the last
// word the front reduces the folded hash modulo BUCKETS by a reciprocal
// multiply, first the product and then the remainder, and then queues the
// request; the input stalls while it does so and while the queue is full.
// The back pops a request, reads one way per cycle from the key/count
// memories and compares each registered read, then updates the entry and
// registers the result; a clear skips the lookup. The back keeps up with
// keyed requests whenever WAYS does not exceed KEY_WORDS; a held result
// stalls the back, then the queue, then the input. No clearing pass after
// reset: entry valid bits live in flip-flops and clear at once.
module position_count_hash_table import pcht_pkg::*; #(
    parameter int BUCKETS   = 256,
    parameter int WAYS      = 4,
    parameter int KEY_WORDS = 12
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic [1:0]         i_opcode,
    input  wire logic [WORD_W-1:0]  i_key_word,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic [1:0]              o_status,
    output logic [COUNT_W-1:0]      o_occurrences
);
    localparam int BW = $clog2(BUCKETS);
    localparam int QW = 2 + BW + KEY_WORDS * WORD_W;

    logic          w_push, w_full, w_pop;
    logic [QW-1:0] w_push_data, w_q_data;
    t_hs           w_q_hs;

    // request collection
    pcht_front #(.BUCKETS(BUCKETS), .KEY_WORDS(KEY_WORDS), .BW(BW), .QW(QW)) u_front (
        .i_clk, .i_rst_n, .i_in_valid, .o_in_stall, .i_opcode, .i_key_word,
        .o_push(w_push), .o_push_data(w_push_data), .i_q_full(w_full)
    );

    // request queue
    pcht_fifo #(.WIDTH(QW)) u_fifo (
        .i_clk, .i_rst_n, .i_push(w_push), .i_data(w_push_data), .o_full(w_full),
        .i_pop(w_pop), .o_hs(w_q_hs), .o_data(w_q_data)
    );

    // table operations
    pcht_back #(.BUCKETS(BUCKETS), .WAYS(WAYS), .KEY_WORDS(KEY_WORDS),
                .BW(BW), .QW(QW)) u_back (
        .i_clk, .i_rst_n, .i_q_hs(w_q_hs), .i_q_data(w_q_data), .o_pop(w_pop),
        .o_out_valid, .i_out_stall, .o_status, .o_occurrences
    );
endmodule
`default_nettype wire

@@ sim/position_count_hash_table_tb.sv @@
// self-checking testbench for the position count hash table
`timescale 1ns / 1ps
module position_count_hash_table_tb;
    import pcht_pkg::*;

    localparam int BUCKETS   = 256;
    localparam int WAYS      = 4;
    localparam int KEY_WORDS = 12;
    localparam int ENTRIES   = BUCKETS * WAYS;
    localparam int N_RANDOM_OPS = 78;

    typedef logic [WORD_W-1:0] t_key [KEY_WORDS];

    typedef struct {
        t_status              status;
        logic [COUNT_W-1:0]   occurrences;
    } t_result;

    typedef struct {
        t_opcode              op;
        logic [WORD_W-1:0]    word;
        bit                   checked;
        t_status              status;
        logic [COUNT_W-1:0]   occurrences;
    } t_row;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic [1:0]           i_opcode;
    logic [WORD_W-1:0]    i_key_word;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic [1:0]           o_status;
    logic [COUNT_W-1:0]   o_occurrences;

    position_count_hash_table #(
        .BUCKETS(BUCKETS), .WAYS(WAYS), .KEY_WORDS(KEY_WORDS)
    ) u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_opcode(i_opcode), .i_key_word(i_key_word),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_status(o_status), .o_occurrences(o_occurrences)
    );

    // shadow table state
    logic [WORD_W-1:0]  sh_words [ENTRIES][KEY_WORDS];
    logic [COUNT_W-1:0] sh_counts [ENTRIES];
    bit                 sh_used [ENTRIES];
    logic [WORD_W-1:0]  partial_key [KEY_WORDS];
    int                 words_seen;
    logic [WORD_W-1:0]  hash_acc;

    t_result expected_results [$];
    t_result typed_results [$];
    bit      typed_valid [$];
    int      mismatches;
    bit      rx_hold;
    bit      quiet_idle;
    bit      stim_done;

    t_key    key_pool [16];

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    initial begin
        #50ms;
        $display("== FAIL ==");
        $finish;
    end

    function automatic void reset_table();
        for (int e = 0; e < ENTRIES; e++) sh_used[e] = 1'b0;
        words_seen = 0;
        hash_acc = '0;
    endfunction

    // predict the result of one accepted request; returns 1 when a result follows
    function automatic bit predict_request(t_opcode op, logic [WORD_W-1:0] word,
                                           output t_result res);
        logic [WORD_W-1:0] folded;
        int base, hit, free_e;
        bit found, has_free, same;
        res.status = ST_OK;
        res.occurrences = '0;
        if (op == OP_CLEAR) begin
            for (int e = 0; e < ENTRIES; e++) sh_used[e] = 1'b0;
            words_seen = 0;
            hash_acc = '0;
            return 1'b1;
        end
        if (words_seen >= KEY_WORDS) words_seen = 0;
        partial_key[words_seen] = word;
        hash_acc ^= ~word;
        words_seen++;
        if (words_seen < KEY_WORDS) return 1'b0;
        folded = ((hash_acc >> HALF_W) ^ hash_acc) & 64'h7FFF_FFFF;
        base = int'(folded % BUCKETS) * WAYS;
        words_seen = 0;
        hash_acc = '0;
        found = 1'b0;
        has_free = 1'b0;
        hit = 0;
        free_e = 0;
        for (int w = 0; w < WAYS; w++) begin
            if (sh_used[base + w]) begin
                if (!found) begin
                    same = 1'b1;
                    for (int i = 0; i < KEY_WORDS; i++)
                        if (sh_words[base + w][i] !== partial_key[i]) same = 1'b0;
                    if (same) begin
                        found = 1'b1;
                        hit = base + w;
                    end
                end
            end else if (!has_free) begin
                has_free = 1'b1;
                free_e = base + w;
            end
        end
        if (op == OP_ADD) begin
            if (found) begin
                if (sh_counts[hit] != COUNT_MAX) sh_counts[hit]++;
                res.occurrences = sh_counts[hit];
            end else if (has_free) begin
                for (int i = 0; i < KEY_WORDS; i++) sh_words[free_e][i] = partial_key[i];
                sh_counts[free_e] = 1;
                sh_used[free_e] = 1'b1;
                res.occurrences = 1;
            end else begin
                res.status = ST_FULL;
            end
            return 1'b1;
        end
        if (!found) begin
            res.status = ST_NOT_FOUND;
            return 1'b1;
        end
        if (op == OP_REMOVE) begin
            if (sh_counts[hit] > 1) begin
                sh_counts[hit]--;
                res.occurrences = sh_counts[hit];
            end else begin
                sh_used[hit] = 1'b0;
            end
        end else begin
            res.occurrences = sh_counts[hit];
        end
        return 1'b1;
    endfunction

    // drive one request and wait for acceptance
    task automatic send_request(t_opcode op, logic [WORD_W-1:0] word,
                                bit checked, t_result typed);
        t_result res;
        while (!quiet_idle && $urandom_range(99) < 33) begin
            i_in_valid <= 1'b0;
            i_opcode <= 2'($urandom);
            i_key_word <= {$urandom, $urandom};
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_opcode <= op;
        i_key_word <= word;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        if (predict_request(op, word, res)) begin
            expected_results.push_back(res);
            typed_valid.push_back(checked);
            typed_results.push_back(typed);
        end
    endtask

    // full key with a random opcode mix on the non-final words
    task automatic send_key(input t_key key, input t_opcode op);
        t_result none;
        none = '{ST_OK, '0};
        for (int i = 0; i < KEY_WORDS - 1; i++)
            send_request(t_opcode'($urandom_range(2)), key[i], 1'b0, none);
        send_request(op, key[KEY_WORDS-1], 1'b0, none);
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_result exp_r;
        bit      have_typed;
        t_result typed;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result status=%0d occ=%0d", o_status, o_occurrences);
            end else begin
                exp_r = expected_results.pop_front();
                have_typed = typed_valid.pop_front();
                typed = typed_results.pop_front();
                if (have_typed && (typed.status != exp_r.status ||
                                   typed.occurrences != exp_r.occurrences)) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("table row disagrees: row %0d/%0d predictor %0d/%0d",
                                 typed.status, typed.occurrences,
                                 exp_r.status, exp_r.occurrences);
                end
                if (o_status !== exp_r.status || o_occurrences !== exp_r.occurrences) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected status=%0d occ=%0d, got status=%0d occ=%0d",
                                 exp_r.status, exp_r.occurrences, o_status, o_occurrences);
                end
            end
        end
    end

    // receiver stall pattern, with one long hold-off
    always @(posedge i_clk) begin
        if (rx_hold) i_out_stall <= 1'b1;
        else if (quiet_idle) i_out_stall <= 1'b0;
        else i_out_stall <= ($urandom_range(99) < 33);
    end

    initial begin
        rx_hold = 1'b0;
        @(posedge i_clk);
        wait (stim_done == 1'b0 && i_rst_n);
        repeat (200) @(posedge i_clk);
        rx_hold = 1'b1;
        repeat (300) @(posedge i_clk);
        rx_hold = 1'b0;
    end

    // a key that lands in a chosen bucket by fixing its last word
    function automatic void bucket_key(output t_key key, input int bucket);
        logic [WORD_W-1:0] acc;
        logic [WORD_W-1:0] target;
        acc = '0;
        for (int i = 0; i < KEY_WORDS - 1; i++) begin
            key[i] = {$urandom, $urandom};
            acc ^= ~key[i];
        end
        target = {32'($urandom_range(255)), 32'(bucket)};
        target[31] = 1'b0;
        // fold of (acc ^ ~last) must equal bucket: choose high half, solve low half
        target[31:0] = {1'b0, 31'(bucket)} ^ target[63:32];
        key[KEY_WORDS-1] = ~(acc ^ target);
    endfunction

    initial begin
        t_row    rows [$];
        t_result typed;
        t_key    k;
        int      waited;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_opcode = OP_ADD;
        i_key_word = '0;
        mismatches = 0;
        quiet_idle = 1'b0;
        stim_done = 1'b1;
        reset_table();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        stim_done = 1'b0;

        // directed table: extremes, clear, get and remove, clear at the start and mid-key
        rows.push_back('{OP_CLEAR, '0, 1'b1, ST_OK, 32'd0});
        for (int i = 0; i < KEY_WORDS - 1; i++)
            rows.push_back('{OP_GET, '1, 1'b0, ST_OK, 32'd0});
        rows.push_back('{OP_GET, '1, 1'b1, ST_NOT_FOUND, 32'd0});
        rows.push_back('{OP_REMOVE, '0, 1'b0, ST_OK, 32'd0});
        rows.push_back('{OP_CLEAR, '1, 1'b1, ST_OK, 32'd0});
        foreach (rows[r])
            send_request(rows[r].op, rows[r].word, rows[r].checked,
                         '{rows[r].status, rows[r].occurrences});
        typed = '{ST_OK, '0};
        for (int i = 0; i < KEY_WORDS; i++) k[i] = '1;
        send_key(k, OP_ADD);
        send_key(k, OP_ADD);
        send_key(k, OP_GET);
        send_key(k, OP_REMOVE);
        send_key(k, OP_REMOVE);
        send_key(k, OP_REMOVE);

        // bucket fill past WAYS, then random traffic over a small key pool
        for (int j = 0; j < WAYS + 2; j++) begin
            bucket_key(k, 7);
            send_key(k, OP_ADD);
        end
        for (int p = 0; p < 16; p++)
            bucket_key(key_pool[p], $urandom_range(3));
        for (int n = 0; n < N_RANDOM_OPS; n++) begin
            if (n == 20) quiet_idle = 1'b1;
            if (n == 35) quiet_idle = 1'b0;
            case ($urandom_range(19))
                0: send_request(OP_CLEAR, {$urandom, $urandom}, 1'b0, typed);
                1: begin
                    for (int i = 0; i < KEY_WORDS; i++) k[i] = {$urandom, $urandom};
                    send_key(k, t_opcode'($urandom_range(2)));
                end
                default: send_key(key_pool[$urandom_range(15)],
                                  t_opcode'($urandom_range(9) < 5 ? 0 : $urandom_range(2)));
            endcase
        end
        i_in_valid <= 1'b0;
        stim_done = 1'b1;

        waited = 0;
        while (expected_results.size() != 0 && waited < 100000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (50) @(posedge i_clk);
        if (expected_results.size() != 0) mismatches++;
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule

@@ sim.f @@
rtl/pcht_pkg.sv
rtl/pcht_fifo.sv
rtl/pcht_front.sv
rtl/pcht_back.sv
rtl/position_count_hash_table.sv
sim/position_count_hash_table_tb.sv
